>>> rtl/ecc_pkg.sv
// ----------------------------------------------------------------------------
// Epoch calendar converter package
// Shared constants and the month offset table of the day number method.
// ----------------------------------------------------------------------------
package ecc_pkg;

  localparam logic [23:0] BASE_JDN_RESET = 24'd2440588;
  localparam int unsigned NUM_STAGES     = 15;

  typedef enum logic {
    FUNC_TO_EPOCH   = 1'b0,
    FUNC_FROM_EPOCH = 1'b1
  } func_e;

  // Reciprocals for division by constants: floor(2^k / d) with k equal to
  // the width of the dividend, so the estimate is low by at most one.
  localparam int unsigned RecipDay  = (1 << 25) / 675;
  localparam int unsigned RecipQuad = (1 << 27) / 146097;
  localparam int unsigned RecipHour = (1 << 13) / 225;
  localparam int unsigned RecipMin  = (1 << 15) / 15;
  localparam int unsigned RecipQuy  = (1 << 19) / 1461;
  localparam int unsigned RecipMon  = (1 << 11) / 153;

  // Days before the start of a shifted month: (153 * m + 2) / 5.
  function automatic logic [8:0] ecc_month_days(input logic [3:0] m);
    logic [8:0] res;
    unique case (m)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      4'd12:   res = 9'd367;
      4'd13:   res = 9'd398;
      4'd14:   res = 9'd428;
      default: res = 9'd459;
    endcase
    return res;
  endfunction

endpackage

>>> rtl/ecc_in_if.sv
// ----------------------------------------------------------------------------
// Epoch calendar converter input channel
// Valid and ready handshake carrying one conversion request.
// ----------------------------------------------------------------------------
interface ecc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [6:0] year_in;
  logic [3:0] month_in;
  logic [4:0] day_in;
  logic [4:0] hour_in;
  logic [5:0] minute_in;
  logic [5:0] second_in;
  logic [31:0] epoch_in;

  modport source (
    output valid, func, year_in, month_in, day_in, hour_in, minute_in, second_in,
    output epoch_in,
    input  ready
  );
  modport sink (
    input  valid, func, year_in, month_in, day_in, hour_in, minute_in, second_in,
    input  epoch_in,
    output ready
  );
endinterface

>>> rtl/ecc_out_if.sv
// ----------------------------------------------------------------------------
// Epoch calendar converter output channel
// Valid and ready handshake carrying one conversion result.
// ----------------------------------------------------------------------------
interface ecc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_out;
  logic [7:0]  year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;

  modport source (
    output valid, epoch_out, year_out, month_out, day_out, hour_out,
    output minute_out, second_out,
    input  ready
  );
  modport sink (
    input  valid, epoch_out, year_out, month_out, day_out, hour_out,
    input  minute_out, second_out,
    output ready
  );
endinterface

>>> rtl/epoch_calendar_converter_core.sv
// ----------------------------------------------------------------------------
// Epoch calendar converter core
// Converts calendar fields to epoch seconds and back, fifteen stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken on in_i when valid and ready are both high; func selects
// calendar to epoch (0) or epoch to calendar (1). Each request gives exactly
// one result on out_o, in order, and the fields unused by the chosen
// direction read as zero.
// One transaction can be accepted in every cycle unless a waiting result is
// held by out_o.ready being low. The depth is set by the chain of reciprocal
// divisions in the epoch to calendar direction, each taking a multiply stage,
// a remainder stage and a correction stage.
// When the receiver holds ready low while a result waits, the whole pipeline
// holds and in_i.ready falls; nothing is lost or repeated.
// The base Julian day register is written through cfg_we_i and cfg_wdata_i;
// the user must write it only while the block is idle, which the block itself
// does not enforce. Reset empties the pipeline and sets the base to 1970-01-01.
// ----------------------------------------------------------------------------
module epoch_calendar_converter_core
  import ecc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  ecc_in_if.sink      in_i,
  ecc_out_if.source   out_o
);

  logic                  en;
  logic [NUM_STAGES-1:0] vld_q;
  logic [23:0]           base_q;
  logic [NUM_STAGES-1:0] func_q;

  logic        in_early;
  logic [12:0] in_yrs;
  logic [3:0]  in_mon;

  logic [31:0] s1_ep_q;
  logic [40:0] s1_prod_q;
  logic [12:0] s1_yrs_q;
  logic [3:0]  s1_mon_q;
  logic [4:0]  s1_dd_q;
  logic [16:0] s1_hms_q;

  logic [31:0] s2_days_q;
  logic [16:0] s2_hms_q;
  logic [15:0] s2_q0_q;
  logic [17:0] s2_r0_q;

  logic [31:0] s3_jdn_q;
  logic [16:0] s3_hms_q;
  logic [24:0] s3_a_q;
  logic [16:0] s3_r_q;
  logic        s3_ge;

  logic [31:0] s4_esec_q;
  logic [16:0] s4_hms_q;
  logic [26:0] s4_xb_q;
  logic [24:0] s4_a_q;
  logic [36:0] s4_prodb_q;
  logic [18:0] s4_prodh_q;
  logic [26:0] s4_prodm_q;
  logic [16:0] s4_r_q;

  logic [31:0] s5_epoch_q;
  logic [24:0] s5_a_q;
  logic [16:0] s5_r_q;
  logic [9:0]  s5_b0_q;
  logic [18:0] s5_tb_q;
  logic [5:0]  s5_h0_q;
  logic [8:0]  s5_th_q;
  logic [11:0] s5_m0_q;
  logic [4:0]  s5_tm_q;

  logic [31:0] s6_epoch_q;
  logic [24:0] s6_a_q;
  logic [16:0] s6_r_q;
  logic [9:0]  s6_b_q;
  logic [4:0]  s6_h_q;
  logic [10:0] s6_m_q;

  logic [NUM_STAGES-1:7][31:0] ep_dly_q;
  logic [NUM_STAGES-1:7][9:0]  b_dly_q;
  logic [NUM_STAGES-1:7][4:0]  hr_dly_q;
  logic [NUM_STAGES-1:7][5:0]  mi_dly_q;
  logic [NUM_STAGES-1:7][5:0]  se_dly_q;

  logic [16:0] s7_a2_q;
  logic [18:0] s8_xc_q;
  logic [16:0] s8_a2_q;
  logic [27:0] s8_prodc_q;
  logic [8:0]  s9_c0_q;
  logic [11:0] s9_tc_q;
  logic [16:0] s9_a2_q;
  logic [6:0]  s10_c_q;
  logic [16:0] s10_a2_q;
  logic [6:0]  c_dly11_q, c_dly12_q, c_dly13_q, c_dly14_q;
  logic [8:0]  s11_a3_q;
  logic [10:0] s12_xd_q;
  logic [14:0] s12_prodd_q;
  logic [8:0]  s12_a3_q;
  logic [3:0]  s13_d0_q;
  logic [8:0]  s13_td_q;
  logic [8:0]  s13_a3_q;
  logic [3:0]  s14_d_q;
  logic [8:0]  s14_a3_q;

  logic        s14_ten;
  logic [15:0] fin_year;
  logic [8:0]  fin_day;
  logic [3:0]  fin_mon;

  logic [31:0] out_epoch_q;
  logic [7:0]  out_year_q;
  logic [3:0]  out_month_q;
  logic [4:0]  out_day_q;
  logic [4:0]  out_hour_q;
  logic [5:0]  out_minute_q;
  logic [5:0]  out_second_q;

  assign en          = !vld_q[NUM_STAGES-1] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = vld_q[NUM_STAGES-1];

  assign in_early = (in_i.month_in <= 4'd2);
  assign in_yrs   = 13'(in_i.year_in) + 13'd6800 - 13'(in_early);
  assign in_mon   = in_i.month_in + (in_early ? 4'd12 : 4'd0) - 4'd3;
  assign s3_ge    = (s2_r0_q >= 18'd86400);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      base_q <= BASE_JDN_RESET;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (en) begin
        vld_q <= {vld_q[NUM_STAGES-2:0], in_i.valid};
      end
    end
  end

  assign s14_ten  = (s14_d_q >= 4'd10);
  assign fin_year = 16'(b_dly_q[14]) * 16'd100 + 16'(c_dly14_q) - 16'd6800
                    + 16'(s14_ten);
  assign fin_day  = s14_a3_q - ecc_month_days(s14_d_q) + 9'd1;
  assign fin_mon  = s14_d_q + 4'd3 - (s14_ten ? 4'd12 : 4'd0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      func_q <= {func_q[NUM_STAGES-2:0], in_i.func};

      // Stage 1: operand set-up and day quotient estimate.
      s1_ep_q   <= in_i.epoch_in;
      s1_prod_q <= 41'(in_i.epoch_in[31:7]) * 41'(RecipDay);
      s1_yrs_q  <= in_yrs;
      s1_mon_q  <= in_mon;
      s1_dd_q   <= in_i.day_in;
      s1_hms_q  <= 17'(in_i.hour_in) * 17'd3600 + 17'(in_i.minute_in) * 17'd60
                   + 17'(in_i.second_in);

      // Stage 2: day count and day remainder.
      s2_days_q <= 32'(s1_yrs_q) * 32'd365 + 32'(s1_dd_q)
                   + 32'(ecc_month_days(s1_mon_q)) + 32'(s1_yrs_q >> 2)
                   - ((s1_yrs_q >= 13'd6900) ? 32'd69 :
                      (s1_yrs_q >= 13'd6800) ? 32'd68 : 32'd67)
                   + ((s1_yrs_q >= 13'd6800) ? 32'd17 : 32'd16);
      s2_hms_q  <= s1_hms_q;
      s2_q0_q   <= s1_prod_q[40:25];
      s2_r0_q   <= 18'(s1_ep_q - 32'(s1_prod_q[40:25]) * 32'd86400);

      // Stage 3: Julian day offset, quotient correction.
      s3_jdn_q <= s2_days_q - 32'd32045 - 32'(base_q);
      s3_hms_q <= s2_hms_q;
      s3_a_q   <= 25'(s2_q0_q) + 25'(s3_ge) + 25'(base_q) + 25'd32044;
      s3_r_q   <= 17'(s2_r0_q - (s3_ge ? 18'd86400 : 18'd0));

      // Stage 4: seconds of the day count and quotient estimates.
      s4_esec_q  <= s3_jdn_q * 32'd86400;
      s4_hms_q   <= s3_hms_q;
      s4_xb_q    <= {s3_a_q, 2'b11};
      s4_a_q     <= s3_a_q;
      s4_prodb_q <= 37'({s3_a_q, 2'b11}) * 37'(RecipQuad);
      s4_prodh_q <= 19'(s3_r_q[16:4]) * 19'(RecipHour);
      s4_prodm_q <= 27'(s3_r_q[16:2]) * 27'(RecipMin);
      s4_r_q     <= s3_r_q;

      // Stage 5: epoch sum, remainders of the estimates.
      s5_epoch_q <= s4_esec_q + 32'(s4_hms_q);
      s5_a_q     <= s4_a_q;
      s5_r_q     <= s4_r_q;
      s5_b0_q    <= s4_prodb_q[36:27];
      s5_tb_q    <= 19'(s4_xb_q - 27'(s4_prodb_q[36:27]) * 27'd146097);
      s5_h0_q    <= s4_prodh_q[18:13];
      s5_th_q    <= 9'(s4_r_q[16:4] - 13'(s4_prodh_q[18:13]) * 13'd225);
      s5_m0_q    <= s4_prodm_q[26:15];
      s5_tm_q    <= 5'(s4_r_q[16:2] - 15'(s4_prodm_q[26:15]) * 15'd15);

      // Stage 6: quotient corrections.
      s6_epoch_q <= s5_epoch_q;
      s6_a_q     <= s5_a_q;
      s6_r_q     <= s5_r_q;
      s6_b_q     <= s5_b0_q + 10'(s5_tb_q >= 19'd146097);
      s6_h_q     <= 5'(s5_h0_q + 6'(s5_th_q >= 9'd225));
      s6_m_q     <= 11'(s5_m0_q + 12'(s5_tm_q >= 5'd15));

      // Stage 7: day within the quadricentennial cycle, minute and second.
      s7_a2_q      <= 17'(s6_a_q - 25'((27'(s6_b_q) * 27'd146097) >> 2));
      ep_dly_q[7]  <= s6_epoch_q;
      b_dly_q[7]   <= s6_b_q;
      hr_dly_q[7]  <= s6_h_q;
      mi_dly_q[7]  <= 6'(s6_m_q - 11'(s6_h_q) * 11'd60);
      se_dly_q[7]  <= 6'(s6_r_q - 17'(s6_m_q) * 17'd60);

      for (int i = 8; i < NUM_STAGES; i++) begin
        ep_dly_q[i] <= ep_dly_q[i-1];
        b_dly_q[i]  <= b_dly_q[i-1];
        hr_dly_q[i] <= hr_dly_q[i-1];
        mi_dly_q[i] <= mi_dly_q[i-1];
        se_dly_q[i] <= se_dly_q[i-1];
      end

      // Stages 8 to 11: year within the century, then day within the year.
      s8_xc_q    <= {s7_a2_q[16:0], 2'b11};
      s8_a2_q    <= s7_a2_q;
      s8_prodc_q <= 28'({s7_a2_q, 2'b11}) * 28'(RecipQuy);
      s9_c0_q    <= s8_prodc_q[27:19];
      s9_tc_q    <= 12'(s8_xc_q - 19'(s8_prodc_q[27:19]) * 19'd1461);
      s9_a2_q    <= s8_a2_q;
      s10_c_q    <= 7'(s9_c0_q + 9'(s9_tc_q >= 12'd1461));
      s10_a2_q   <= s9_a2_q;
      s11_a3_q   <= 9'(18'(s10_a2_q) - ((18'(s10_c_q) * 18'd1461) >> 2));
      c_dly11_q  <= s10_c_q;
      c_dly12_q  <= c_dly11_q;
      c_dly13_q  <= c_dly12_q;
      c_dly14_q  <= c_dly13_q;

      // Stages 12 to 14: shifted month.
      s12_xd_q    <= 11'(s11_a3_q) * 11'd5 + 11'd2;
      s12_prodd_q <= 15'(11'(s11_a3_q) * 11'd5 + 11'd2) * 15'(RecipMon);
      s12_a3_q    <= s11_a3_q;
      s13_d0_q    <= s12_prodd_q[14:11];
      s13_td_q    <= 9'(s12_xd_q - 11'(s12_prodd_q[14:11]) * 11'd153);
      s13_a3_q    <= s12_a3_q;
      s14_d_q     <= s13_d0_q + 4'(s13_td_q >= 9'd153);
      s14_a3_q    <= s13_a3_q;

      // Stage 15: output register.
      if (func_q[NUM_STAGES-2] == FUNC_FROM_EPOCH) begin
        out_epoch_q  <= '0;
        out_year_q   <= fin_year[7:0];
        out_month_q  <= fin_mon;
        out_day_q    <= fin_day[4:0];
        out_hour_q   <= hr_dly_q[14];
        out_minute_q <= mi_dly_q[14];
        out_second_q <= se_dly_q[14];
      end else begin
        out_epoch_q  <= ep_dly_q[14];
        out_year_q   <= '0;
        out_month_q  <= '0;
        out_day_q    <= '0;
        out_hour_q   <= '0;
        out_minute_q <= '0;
        out_second_q <= '0;
      end
    end
  end

  assign out_o.epoch_out  = out_epoch_q;
  assign out_o.year_out   = out_year_q;
  assign out_o.month_out  = out_month_q;
  assign out_o.day_out    = out_day_q;
  assign out_o.hour_out   = out_hour_q;
  assign out_o.minute_out = out_minute_q;
  assign out_o.second_out = out_second_q;

endmodule
